// ===== src/assert_macros.svh =====
// Assertion helpers shared by the keypad entry RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define KPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define KPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/kpd_pkg.sv =====
// ----------------------------------------------------------------------------
// kpd_pkg
// Types, codes and the key map shared by the keypad scanner and entry logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kpd_pkg;

  localparam int KEYS_HELD_DEF = 4;
  localparam int KEY_SLOTS     = 4;
  localparam int GAP_W         = 16;
  localparam logic [GAP_W-1:0] SHORT_GAP_RST  = 16'd500;
  localparam logic [GAP_W-1:0] REPEAT_GAP_RST = 16'd1000;
  localparam logic [GAP_W-1:0] ELAPSED_MAX    = 16'hffff;
  localparam logic [2:0]       NONE_POS       = 3'h7;

  typedef enum logic [1:0] {
    REQ_SCAN  = 2'd0,
    REQ_MS    = 2'd1,
    REQ_ROW   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic {
    CFG_SHORT_GAP  = 1'b0,
    CFG_REPEAT_GAP = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]                 column_drive;
    logic                       asleep;
    logic [2:0]                 key_count;
    logic [KEY_SLOTS-1:0][7:0]  keys;
    logic                       accepted;
  } result_t;

  function automatic logic [7:0] key_code(input logic [1:0] row, input logic [1:0] col);
    logic [7:0] code;
    code = 8'h00;
    case ({row, col})
      4'b00_00: code = "#";
      4'b00_01: code = "0";
      4'b00_10: code = "*";
      4'b01_00: code = "9";
      4'b01_01: code = "8";
      4'b01_10: code = "7";
      4'b10_00: code = "6";
      4'b10_01: code = "5";
      4'b10_10: code = "4";
      4'b11_00: code = "3";
      4'b11_01: code = "2";
      4'b11_10: code = "1";
      default:  code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// ===== src/kpd_core.sv =====
// ----------------------------------------------------------------------------
// kpd_core
// Scan phase, debounce timer, entry count and key store; one request per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kpd_core #(
  parameter int KEYS_HELD = kpd_pkg::KEYS_HELD_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req_fire,
  input  logic [1:0]               req_type,
  input  logic [3:0]               row_hits,
  input  logic [kpd_pkg::GAP_W-1:0] short_gap,
  input  logic [kpd_pkg::GAP_W-1:0] repeat_gap,
  output kpd_pkg::result_t         result
);

  localparam int CntRaw = $clog2(KEYS_HELD + 2);
  localparam int CntW   = (CntRaw > 3) ? CntRaw : 3;
  localparam int IdxW   = (KEYS_HELD > 1) ? $clog2(KEYS_HELD) : 1;
  localparam int GapW   = kpd_pkg::GAP_W;
  localparam logic [CntW-1:0] CntHeld = CntW'(KEYS_HELD);
  localparam logic [CntW-1:0] CntFull = CntW'(KEYS_HELD + 1);

  logic [2:0]                  phase_r, phase_nxt;
  logic                        sleeping_r, sleeping_nxt;
  logic [CntW-1:0]             count_r, count_nxt;
  logic [2:0]                  prev_row_r, prev_row_nxt;
  logic [2:0]                  prev_col_r, prev_col_nxt;
  logic [kpd_pkg::GAP_W-1:0]   elapsed_r, elapsed_nxt;
  logic [7:0]                  store_r [KEYS_HELD];
  logic [7:0]                  store_nxt [KEYS_HELD];
  kpd_pkg::req_t               req;
  logic [1:0]                  col;
  logic [1:0]                  row;
  logic                        gap_ok;
  logic                        take;
  logic [IdxW-1:0]             wr_idx;
  logic [CntW-1:0]             held;
  logic [3:0]                  col_onehot;

  assign req    = kpd_pkg::req_t'(req_type);
  assign col    = phase_r[2:1];
  assign wr_idx = count_r[IdxW-1:0];

  always_comb begin
    if (row_hits[3]) begin
      row = 2'd3;
    end else if (row_hits[2]) begin
      row = 2'd2;
    end else if (row_hits[1]) begin
      row = 2'd1;
    end else begin
      row = 2'd0;
    end
  end

  assign gap_ok = (elapsed_r > short_gap) &&
                  ((elapsed_r > repeat_gap) || (prev_col_r != {1'b0, col}) ||
                   (prev_row_r != {1'b0, row}));

  always_comb begin
    phase_nxt    = phase_r;
    sleeping_nxt = sleeping_r;
    count_nxt    = count_r;
    prev_row_nxt = prev_row_r;
    prev_col_nxt = prev_col_r;
    elapsed_nxt  = elapsed_r;
    take         = 1'b0;
    case (req)
      kpd_pkg::REQ_SCAN: begin
        if (!sleeping_r && (count_r <= CntHeld)) begin
          phase_nxt = phase_r + 3'd1;
        end
      end
      kpd_pkg::REQ_MS: begin
        if (elapsed_r != kpd_pkg::ELAPSED_MAX) begin
          elapsed_nxt = elapsed_r + GapW'(1);
        end
      end
      kpd_pkg::REQ_ROW: begin
        if (sleeping_r) begin
          sleeping_nxt = 1'b0;
          count_nxt    = '0;
        end else if ((row_hits != 4'd0) && (col != 2'd3)) begin
          if (gap_ok) begin
            elapsed_nxt = '0;
            if (count_r < CntHeld) begin
              take      = 1'b1;
              count_nxt = count_r + CntW'(1);
            end else begin
              count_nxt = CntFull;
            end
          end
          prev_row_nxt = {1'b0, row};
          prev_col_nxt = {1'b0, col};
        end
      end
      kpd_pkg::REQ_CLEAR: begin
        sleeping_nxt = 1'b1;
        count_nxt    = '0;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_comb begin
    for (int e = 0; e < KEYS_HELD; e++) begin
      if (take && (wr_idx == IdxW'(e))) begin
        store_nxt[e] = kpd_pkg::key_code(row, col);
      end else begin
        store_nxt[e] = store_r[e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      sleeping_r <= 1'b1;
      count_r    <= '0;
      prev_row_r <= kpd_pkg::NONE_POS;
      prev_col_r <= kpd_pkg::NONE_POS;
      elapsed_r  <= '0;
    end else if (req_fire) begin
      phase_r    <= phase_nxt;
      sleeping_r <= sleeping_nxt;
      count_r    <= count_nxt;
      prev_row_r <= prev_row_nxt;
      prev_col_r <= prev_col_nxt;
      elapsed_r  <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      for (int e = 0; e < KEYS_HELD; e++) begin
        store_r[e] <= store_nxt[e];
      end
    end
  end

  assign held       = sleeping_nxt ? '0 : ((count_nxt > CntHeld) ? CntHeld : count_nxt);
  assign col_onehot = 4'b0001 << phase_nxt[2:1];

  always_comb begin
    if (sleeping_nxt) begin
      result.column_drive = 3'b111;
    end else if (count_nxt > CntHeld) begin
      result.column_drive = 3'b000;
    end else if (phase_nxt[0]) begin
      result.column_drive = col_onehot[2:0];
    end else begin
      result.column_drive = 3'b000;
    end
  end

  assign result.asleep    = sleeping_nxt;
  assign result.key_count = sleeping_nxt ? 3'd0 : count_nxt[2:0];
  assign result.accepted  = take;

  for (genvar i = 0; i < kpd_pkg::KEY_SLOTS; i++) begin : g_slot
    if (i < KEYS_HELD) begin : g_held
      assign result.keys[i] = (CntW'(i) < held) ? store_nxt[i] : 8'h00;
    end else begin : g_empty
      assign result.keys[i] = 8'h00;
    end
  end

  `KPD_ASSERT(a_count_range, count_r <= CntFull, "entry count beyond full")
  `KPD_ASSERT_IMPL(a_sleep_empty, sleeping_r, count_r == '0, "count held while asleep")
  `KPD_ASSERT_NEXT(a_take_counts, req_fire && take,
                   count_r == CntW'($past(count_r) + 1'b1), "stored key not counted")

endmodule

// ===== src/kpd_out_stage.sv =====
// ----------------------------------------------------------------------------
// kpd_out_stage
// Result register with valid flag; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kpd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  kpd_pkg::result_t result_in,
  output logic             out_valid,
  input  logic             out_ready,
  output kpd_pkg::result_t result_out
);

  logic             valid_r;
  kpd_pkg::result_t data_r;
  logic             load;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result_in;
    end
  end

  assign out_valid  = valid_r;
  assign result_out = data_r;

  `KPD_ASSERT_NEXT(a_load_shows, load, valid_r, "loaded result not presented")
  `KPD_ASSERT_NEXT(a_stall_holds, valid_r && !out_ready, data_r == $past(data_r),
                   "stalled result changed")
  `KPD_ASSERT_NEXT(a_drain_clears, valid_r && out_ready && !load, !valid_r,
                   "drained result still valid")

endmodule

// ===== src/keypad_scan_debounce_entry_unit.sv =====
// ----------------------------------------------------------------------------
// keypad_scan_debounce_entry_unit
// The result of an accepted request is registered and shown in the next cycle.
// Throughput: one request per cycle; the input stalls only while a result is held back.
// Reset (synchronous, active low): asleep, count zero, phase and timer zero,
// previous row and column none, gaps 500 and 1000 ms. Key store is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_scan_debounce_entry_unit #(
  parameter int KEYS_HELD = kpd_pkg::KEYS_HELD_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [kpd_pkg::GAP_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_req_type,
  input  logic [3:0]                in_row_hits,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_column_drive,
  output logic                      out_asleep,
  output logic [2:0]                out_key_count,
  output logic [7:0]                out_key_first,
  output logic [7:0]                out_key_second,
  output logic [7:0]                out_key_third,
  output logic [7:0]                out_key_fourth,
  output logic                      out_accepted
);

  logic [kpd_pkg::GAP_W-1:0] short_gap_r;
  logic [kpd_pkg::GAP_W-1:0] repeat_gap_r;
  kpd_pkg::result_t          core_result;
  kpd_pkg::result_t          out_result;
  logic                      in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_gap_r  <= kpd_pkg::SHORT_GAP_RST;
      repeat_gap_r <= kpd_pkg::REPEAT_GAP_RST;
    end else if (cfg_we) begin
      case (kpd_pkg::cfg_idx_t'(cfg_index))
        kpd_pkg::CFG_SHORT_GAP:  short_gap_r  <= cfg_data;
        kpd_pkg::CFG_REPEAT_GAP: repeat_gap_r <= cfg_data;
        default:                 short_gap_r  <= short_gap_r;
      endcase
    end
  end

  assign in_fire = in_valid && in_ready;

  kpd_core #(
    .KEYS_HELD(KEYS_HELD)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_fire  (in_fire),
    .req_type  (in_req_type),
    .row_hits  (in_row_hits),
    .short_gap (short_gap_r),
    .repeat_gap(repeat_gap_r),
    .result    (core_result)
  );

  kpd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .result_in (core_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_out(out_result)
  );

  assign out_column_drive = out_result.column_drive;
  assign out_asleep       = out_result.asleep;
  assign out_key_count    = out_result.key_count;
  assign out_key_first    = out_result.keys[0];
  assign out_key_second   = out_result.keys[1];
  assign out_key_third    = out_result.keys[2];
  assign out_key_fourth   = out_result.keys[3];
  assign out_accepted     = out_result.accepted;

endmodule

// ===== test/keypad_entry_checker.sv =====
// ----------------------------------------------------------------------------
// Keypad entry checker
// Watches the request, result and register ports of the keypad scanner,
// keeps its own copy of the scan, debounce and entry state, predicts one
// result per accepted request and compares it field by field with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_entry_checker
  import kpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [GAP_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       in_req_type,
  input  logic [3:0]       in_row_hits,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [2:0]       out_column_drive,
  input  logic             out_asleep,
  input  logic [2:0]       out_key_count,
  input  logic [7:0]       out_key_first,
  input  logic [7:0]       out_key_second,
  input  logic [7:0]       out_key_third,
  input  logic [7:0]       out_key_fourth,
  input  logic             out_accepted,
  output int               fail_count,
  output int               pending,
  output int               keys_stored,
  output int               entries_filled
);

  localparam int SLOTS = KEYS_HELD_DEF;
  localparam logic [95:0] KEY_LEGEND = "#0*987654321";

  logic [2:0]       phase_q;
  logic             asleep_q;
  logic [2:0]       count_q;
  logic [2:0]       prev_row_q;
  logic [2:0]       prev_col_q;
  logic [GAP_W-1:0] elapsed_q;
  logic [GAP_W-1:0] short_gap_q;
  logic [GAP_W-1:0] repeat_gap_q;
  logic [7:0]       entry_keys [SLOTS];

  result_t expected_results [$];
  int      errors = 0;
  int      stored = 0;
  int      filled = 0;
  int      backlog = 0;

  assign fail_count     = errors;
  assign pending        = backlog;
  assign keys_stored    = stored;
  assign entries_filled = filled;

  task automatic predict_entry(input req_t req, input logic [3:0] hits, output result_t res);
    logic [2:0] col;
    logic [2:0] row;
    logic       taken;
    int         held;
    int         drive;
    int         pick;
    taken = 1'b0;
    col = phase_q >> 1;
    case (req)
      REQ_SCAN: begin
        if (!asleep_q && count_q <= SLOTS) phase_q = phase_q + 3'd1;
      end
      REQ_MS: begin
        if (elapsed_q != ELAPSED_MAX) elapsed_q = elapsed_q + GAP_W'(1);
      end
      REQ_ROW: begin
        if (asleep_q) begin
          asleep_q = 1'b0;
          count_q = 3'd0;
        end else if (hits != 4'd0 && col <= 3'd2) begin
          if (hits[3]) row = 3'd3;
          else if (hits[2]) row = 3'd2;
          else if (hits[1]) row = 3'd1;
          else row = 3'd0;
          if (elapsed_q > short_gap_q &&
              (elapsed_q > repeat_gap_q || prev_col_q != col || prev_row_q != row)) begin
            elapsed_q = '0;
            if (count_q < SLOTS) begin
              pick = int'(row) * 3 + int'(col);
              entry_keys[count_q[1:0]] = KEY_LEGEND[95 - 8 * pick -: 8];
              count_q = count_q + 3'd1;
              taken = 1'b1;
            end else begin
              if (count_q == SLOTS) filled++;
              count_q = 3'(SLOTS + 1);
            end
          end
          prev_col_q = col;
          prev_row_q = row;
        end
      end
      default: begin
        asleep_q = 1'b1;
        count_q = 3'd0;
      end
    endcase
    held = asleep_q ? 0 : (count_q > SLOTS ? SLOTS : int'(count_q));
    drive = phase_q[0] ? (1 << (phase_q >> 1)) : 0;
    res.column_drive = asleep_q ? 3'd7 : (count_q > SLOTS ? 3'd0 : drive[2:0]);
    res.asleep = asleep_q;
    res.key_count = asleep_q ? 3'd0 : count_q;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      res.keys[i] = (i < held) ? entry_keys[i] : 8'h00;
    end
    res.accepted = taken;
    if (taken) stored++;
  endtask

  task automatic check_field(input string label, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t prediction;
    if (!rst_n) begin
      phase_q = 3'd0;
      asleep_q = 1'b1;
      count_q = 3'd0;
      prev_row_q = NONE_POS;
      prev_col_q = NONE_POS;
      elapsed_q = '0;
      short_gap_q = SHORT_GAP_RST;
      repeat_gap_q = REPEAT_GAP_RST;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result arrived with no request outstanding", $time);
        end else begin
          want = expected_results.pop_front();
          check_field("column_drive", 8'(out_column_drive), 8'(want.column_drive));
          check_field("asleep", 8'(out_asleep), 8'(want.asleep));
          check_field("key_count", 8'(out_key_count), 8'(want.key_count));
          check_field("key_first", out_key_first, want.keys[0]);
          check_field("key_second", out_key_second, want.keys[1]);
          check_field("key_third", out_key_third, want.keys[2]);
          check_field("key_fourth", out_key_fourth, want.keys[3]);
          check_field("accepted", 8'(out_accepted), 8'(want.accepted));
        end
      end
      if (in_valid && in_ready) begin
        predict_entry(req_t'(in_req_type), in_row_hits, prediction);
        expected_results.push_back(prediction);
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SHORT_GAP:  short_gap_q = cfg_data;
          CFG_REPEAT_GAP: repeat_gap_q = cfg_data;
          default: ;
        endcase
      end
    end
    backlog <= expected_results.size();
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner testbench
// Drives scan ticks, millisecond ticks, row events and clears into the
// keypad scanner: a directed opening, random traffic under several gap
// settings and idle patterns, and a timed run past the repeat gap followed
// by a quick key sequence. A checker beside the block does the comparison;
// this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import kpd_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [GAP_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_req_type = 2'd0;
  logic [3:0]       in_row_hits = 4'd0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [2:0]       out_column_drive;
  logic             out_asleep;
  logic [2:0]       out_key_count;
  logic [7:0]       out_key_first;
  logic [7:0]       out_key_second;
  logic [7:0]       out_key_third;
  logic [7:0]       out_key_fourth;
  logic             out_accepted;

  int fail_count;
  int pending;
  int keys_stored;
  int entries_filled;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  keypad_scan_debounce_entry_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_row_hits(in_row_hits),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_column_drive(out_column_drive), .out_asleep(out_asleep),
    .out_key_count(out_key_count), .out_key_first(out_key_first),
    .out_key_second(out_key_second), .out_key_third(out_key_third),
    .out_key_fourth(out_key_fourth), .out_accepted(out_accepted)
  );

  keypad_entry_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_row_hits(in_row_hits),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_column_drive(out_column_drive), .out_asleep(out_asleep),
    .out_key_count(out_key_count), .out_key_first(out_key_first),
    .out_key_second(out_key_second), .out_key_third(out_key_third),
    .out_key_fourth(out_key_fourth), .out_accepted(out_accepted),
    .fail_count(fail_count), .pending(pending),
    .keys_stored(keys_stored), .entries_filled(entries_filled)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_request(input req_t req, input logic [3:0] hits);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_row_hits <= hits;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_gaps(input logic [GAP_W-1:0] short_ms, input logic [GAP_W-1:0] repeat_ms);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SHORT_GAP;
    cfg_data <= short_ms;
    @(posedge clk);
    cfg_index <= CFG_REPEAT_GAP;
    cfg_data <= repeat_ms;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(input int count);
    int sent;
    int pick;
    int burst;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        burst = $urandom_range(40, 1);
        repeat (burst) send_request(REQ_MS, 4'($urandom_range(15)));
        sent += burst;
      end else begin
        if (pick < 36) send_request(REQ_SCAN, 4'($urandom_range(15)));
        else if (pick < 64) send_request(REQ_MS, 4'($urandom_range(15)));
        else if (pick < 96) send_request(REQ_ROW, 4'($urandom_range(15)));
        else send_request(REQ_CLEAR, 4'($urandom_range(15)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(REQ_SCAN, 4'h0);
    send_request(REQ_MS, 4'hf);
    send_request(REQ_ROW, 4'h0);
    send_request(REQ_ROW, 4'hf);
    drain_results();
    write_gaps(16'd0, 16'd3);

    send_request(REQ_MS, 4'h0);
    send_request(REQ_ROW, 4'hf);
    send_request(REQ_MS, 4'h0);
    send_request(REQ_MS, 4'h0);
    send_request(REQ_ROW, 4'hf);
    send_request(REQ_ROW, 4'hf);
    repeat (2) send_request(REQ_SCAN, 4'h0);
    send_request(REQ_ROW, 4'h1);
    repeat (4) send_request(REQ_SCAN, 4'h0);
    send_request(REQ_ROW, 4'h2);
    send_request(REQ_SCAN, 4'h0);
    send_request(REQ_ROW, 4'h8);
    send_request(REQ_SCAN, 4'h0);
    send_request(REQ_ROW, 4'h2);
    send_request(REQ_ROW, 4'h4);
    send_request(REQ_MS, 4'h0);
    send_request(REQ_ROW, 4'h8);
    send_request(REQ_SCAN, 4'h0);
    send_request(REQ_MS, 4'h0);
    send_request(REQ_ROW, 4'h1);
    send_request(REQ_CLEAR, 4'hf);
    send_request(REQ_SCAN, 4'h0);
    drain_results();

    write_gaps(16'd0, 16'd0);
    random_traffic(250);
    drain_results();

    sender_idle_pct = 51;
    write_gaps(16'd3, 16'd20);
    random_traffic(250);
    drain_results();

    sender_idle_pct = 0;
    stall_pct = 51;
    write_gaps(16'd0, 16'd65534);
    random_traffic(250);
    drain_results();

    sender_idle_pct = 34;
    stall_pct = 34;
    write_gaps(16'd12, 16'd30);
    random_traffic(250);
    drain_results();

    sender_idle_pct = 0;
    stall_pct = 0;
    write_gaps(16'd0, 16'd60);
    send_request(REQ_CLEAR, 4'h0);
    send_request(REQ_ROW, 4'h5);
    repeat (61) send_request(REQ_MS, 4'($urandom_range(15)));
    repeat (8) begin
      send_request(REQ_ROW, 4'hf);
      send_request(REQ_MS, 4'h0);
      send_request(REQ_SCAN, 4'h0);
    end
    repeat (2) send_request(REQ_MS, 4'h0);
    repeat (8) begin
      send_request(REQ_ROW, 4'hf);
      send_request(REQ_SCAN, 4'h0);
    end
    drain_results();

    $display("Sent %0d requests under six gap settings and four idle patterns.", requests_sent);
    $display("Keys stored: %0d; entries filled to the limit: %0d.", keys_stored, entries_filled);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
